// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the UTF-8 to Latin-1 decoder RTL.
// Each macro expects clk and an active-low rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/u2l_pkg.sv =====
// Package for the UTF-8 to Latin-1 decoder: widths, result type and helpers.
// No dependencies; used by u2l_core and utf8_to_latin1_decoder_top.
`default_nettype none

package u2l_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CAP_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int ACC_W      = 31;
  localparam int PEND_W     = 3;
  localparam int LEN_W      = 3;
  localparam int CMP_W      = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

  localparam logic [CAP_W-1:0]      CAP_RESET = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [PEND_W-1:0]     PEND_MAX  = PEND_W'(5);

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [BYTE_W-1:0] data;
  } u2l_res_t;

  function automatic logic in_range(input logic [ACC_W-1:0] v, input logic [LEN_W-1:0] len);
    logic ok;
    case (len)
      LEN_W'(1): ok = (v <= ACC_W'(32'h7f));
      LEN_W'(2): ok = (v >= ACC_W'(32'h80)) && (v <= ACC_W'(32'h7ff));
      LEN_W'(3): ok = (v >= ACC_W'(32'h800)) && (v <= ACC_W'(32'hffff));
      LEN_W'(4): ok = (v >= ACC_W'(32'h10000)) && (v <= ACC_W'(32'h1fffff));
      LEN_W'(5): ok = (v >= ACC_W'(32'h200000)) && (v <= ACC_W'(32'h3ffffff));
      LEN_W'(6): ok = (v >= ACC_W'(32'h4000000));
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [ACC_W-1:0] cont_bits(input logic [PEND_W-1:0] pend,
                                                 input logic [5:0] bits);
    logic [ACC_W-1:0] ext;
    logic [ACC_W-1:0] r;
    ext = {{(ACC_W-6){1'b0}}, bits};
    case (pend)
      PEND_W'(1): r = ext;
      PEND_W'(2): r = ext << 6;
      PEND_W'(3): r = ext << 12;
      PEND_W'(4): r = ext << 18;
      PEND_W'(5): r = ext << 24;
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/u2l_core.sv =====
// Decode stage of the UTF-8 to Latin-1 decoder: sequence state and per-byte logic.
// Depends on u2l_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module u2l_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       proc,
  input  wire logic [u2l_pkg::BYTE_W-1:0] byte_in,
  input  wire logic [u2l_pkg::CAP_W-1:0]  capacity,
  output u2l_pkg::u2l_res_t               res
);
  import u2l_pkg::*;

  logic [PEND_W-1:0]     pend_r,  pend_nxt;
  logic [ACC_W-1:0]      acc_r,   acc_nxt;
  logic [LEN_W-1:0]      len_r,   len_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic [CAP_W-1:0]  limit;
  logic              full;
  logic              fin;
  logic [ACC_W-1:0]  acc_acc;
  logic [PEND_W-1:0] pend_dec;

  always_comb begin
    limit    = (capacity != '0) ? capacity - CAP_W'(1) : '0;
    full     = CMP_W'(count_r) >= CMP_W'(limit);
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    len_nxt  = len_r;
    count_nxt = count_r;
    fin      = 1'b0;
    acc_acc  = acc_r | cont_bits(pend_r, byte_in[5:0]);
    pend_dec = pend_r - PEND_W'(1);
    res.valid = 1'b0;
    res.last  = 1'b0;
    res.data  = '0;
    if (byte_in == '0) begin
      res.valid = 1'b1;
      res.last  = 1'b1;
      pend_nxt  = '0;
      acc_nxt   = '0;
      len_nxt   = '0;
      count_nxt = '0;
    end else if (!full) begin
      if (pend_r == '0) begin
        unique casez (byte_in)
          8'b1111_110?: begin
            len_nxt = LEN_W'(6);
            acc_nxt = {byte_in[0], 30'b0};
          end
          8'b1111_10??: begin
            len_nxt = LEN_W'(5);
            acc_nxt = {5'b0, byte_in[1:0], 24'b0};
          end
          8'b1111_0???: begin
            len_nxt = LEN_W'(4);
            acc_nxt = {10'b0, byte_in[2:0], 18'b0};
          end
          8'b1110_????: begin
            len_nxt = LEN_W'(3);
            acc_nxt = {15'b0, byte_in[3:0], 12'b0};
          end
          8'b110?_????: begin
            len_nxt = LEN_W'(2);
            acc_nxt = {20'b0, byte_in[4:0], 6'b0};
          end
          8'b0???_????: begin
            len_nxt = LEN_W'(1);
            acc_nxt = {24'b0, byte_in[6:0]};
          end
          default: begin
            len_nxt = '0;
            acc_nxt = '0;
          end
        endcase
        pend_nxt = (len_nxt != '0) ? PEND_W'(len_nxt - LEN_W'(1)) : '0;
        fin      = (len_nxt == LEN_W'(1));
      end else if (pend_r > PEND_MAX || byte_in[7:6] != 2'b10) begin
        pend_nxt = '0;
        acc_nxt  = '0;
      end else begin
        acc_nxt  = acc_acc;
        pend_nxt = pend_dec;
        fin      = (pend_dec == '0);
      end
      if (fin && in_range(acc_nxt, len_nxt)) begin
        res.valid = 1'b1;
        res.data  = acc_nxt[BYTE_W-1:0];
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      acc_r   <= '0;
      len_r   <= '0;
      count_r <= '0;
    end else if (proc) begin
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
    end
  end

  `ASSERT_ALWAYS(a_pend_bounded, pend_r <= PEND_MAX)
  `ASSERT_IMPLIES(a_pend_below_len, pend_r != '0, PEND_W'(len_r) > pend_r)
  `ASSERT_NEXT(a_term_clears, proc && byte_in == '0, count_r == '0 && pend_r == '0)

endmodule

`default_nettype wire

// ===== hdl/utf8_to_latin1_decoder_top.sv =====
// UTF-8 to Latin-1 decoder top level: input register, decode stage, result register.
// Depends on u2l_pkg, u2l_core and assert_macros.svh.
//
// Accepts one UTF-8 byte per clock cycle unless the result side stalls, and emits
// each valid code point as its low byte, at most capacity minus one per string; a
// zero byte gives a zero result with out_tlast high. Throughput is one byte per
// cycle, set by the single decode stage; only back-pressure on the result side
// stalls the input. The user must write the capacity register through the cfg
// port only while no transaction is in flight; the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module utf8_to_latin1_decoder_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [u2l_pkg::BYTE_W-1:0] in_tdata,   // [7:0] in_byte
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [u2l_pkg::BYTE_W-1:0]      out_tdata,  // [7:0] out_byte
  output logic                            out_tlast,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [u2l_pkg::CAP_W-1:0]  cfg_data
);
  import u2l_pkg::*;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic [CAP_W-1:0]  cap_r;
  logic              proc;
  u2l_res_t          res;

  assign proc      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;
  assign cfg_ready = 1'b1;

  u2l_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc     (proc),
    .byte_in  (in_byte_r),
    .capacity (cap_r),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proc) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (proc && res.valid) begin
      out_byte_r <= res.data;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  `ASSERT_NEXT(a_term_emits, proc && in_byte_r == '0, out_valid_r && out_last_r)
  `ASSERT_IMPLIES(a_last_is_zero, out_valid_r && out_last_r, out_byte_r == '0)
  `ASSERT_NEXT(a_stall_holds, out_valid_r && !out_tready, out_valid_r && $stable(out_byte_r))

endmodule

`default_nettype wire

// ===== sim/tb_utf8_to_latin1_decoder_top.sv =====
// Self-checking testbench for utf8_to_latin1_decoder_top: streams UTF-8 bytes in, predicts
// each Latin-1 byte and terminator, and checks every result transaction in order.
// Depends on u2l_pkg and the decoder RTL; needs no files or arguments.
`default_nettype none

module tb_utf8_to_latin1_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_LEN    = 60;
  localparam int DRAIN_WAIT  = 6;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [u2l_pkg::BYTE_W-1:0] data;
    logic                       eos;
  } latin1_char_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [u2l_pkg::BYTE_W-1:0] in_tdata   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [u2l_pkg::BYTE_W-1:0] out_tdata;
  logic                       out_tlast;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [u2l_pkg::CAP_W-1:0]  cfg_data   = '0;

  utf8_to_latin1_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Decoder state as predicted.
  logic [u2l_pkg::CAP_W-1:0]      capacity_reg = '1;
  logic [2:0]                     pend_conts   = '0;
  logic [30:0]                    code_acc     = '0;
  logic [2:0]                     seq_len      = '0;
  logic [u2l_pkg::COUNT_BITS-1:0] emitted      = '0;

  latin1_char_t               expected_chars[$];
  logic [u2l_pkg::BYTE_W-1:0] src_bytes[$];
  int                         queued_total = 0;
  int                         mismatches   = 0;
  bit                         idle_en      = 1'b1;
  int                         hold_reqs    = 0;
  int                         holds_done   = 0;
  int                         hold_left    = 0;
  int                         src_gap      = 0;
  int                         sink_gap     = 0;
  bit                         src_calm     = 1'b0;
  bit                         sink_calm    = 1'b0;
  int                         stall_cycles = 0;
  latin1_char_t               want;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [30:0] code_low(input int len);
    case (len)
      1:       return 31'h0;
      2:       return 31'h80;
      3:       return 31'h800;
      4:       return 31'h10000;
      5:       return 31'h200000;
      default: return 31'h4000000;
    endcase
  endfunction

  function automatic logic [30:0] code_high(input int len);
    case (len)
      1:       return 31'h7f;
      2:       return 31'h7ff;
      3:       return 31'hffff;
      4:       return 31'h1fffff;
      5:       return 31'h3ffffff;
      default: return 31'h7fffffff;
    endcase
  endfunction

  function automatic void close_sequence();
    if (seq_len >= 3'd1 && seq_len <= 3'd6 &&
        code_acc >= code_low(seq_len) && code_acc <= code_high(seq_len)) begin
      expected_chars.push_back('{data: code_acc[7:0], eos: 1'b0});
      if (emitted != '1) emitted = emitted + 1'b1;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [u2l_pkg::COUNT_BITS-1:0] limit;
    int                             len;
    logic [30:0]                    lead_bits;
    if (b == 8'h00) begin
      expected_chars.push_back('{data: 8'h00, eos: 1'b1});
      pend_conts = '0;
      code_acc   = '0;
      seq_len    = '0;
      emitted    = '0;
      return;
    end
    limit = (capacity_reg == '0) ? '0 : capacity_reg - 1'b1;
    if (emitted >= limit) return;
    if (pend_conts == 3'd0) begin
      casez (b)
        8'b1111_110?: begin len = 6; lead_bits = 31'(b[0])   << 30; end
        8'b1111_10??: begin len = 5; lead_bits = 31'(b[1:0]) << 24; end
        8'b1111_0???: begin len = 4; lead_bits = 31'(b[2:0]) << 18; end
        8'b1110_????: begin len = 3; lead_bits = 31'(b[3:0]) << 12; end
        8'b110?_????: begin len = 2; lead_bits = 31'(b[4:0]) << 6;  end
        8'b0???_????: begin len = 1; lead_bits = 31'(b[6:0]);       end
        default:      begin len = 0; lead_bits = '0;                end
      endcase
      if (len == 0) begin
        code_acc = '0;
        seq_len  = '0;
        return;
      end
      code_acc   = lead_bits;
      seq_len    = 3'(len);
      pend_conts = 3'(len - 1);
      if (len == 1) close_sequence();
    end else if (pend_conts > 3'd5 || b[7:6] != 2'b10) begin
      pend_conts = '0;
      code_acc   = '0;
    end else begin
      code_acc   = code_acc | (31'(b[5:0]) << (6 * (pend_conts - 1)));
      pend_conts = pend_conts - 1'b1;
      if (pend_conts == 3'd0) close_sequence();
    end
  endfunction

  function automatic void note_mismatch(input string what, input latin1_char_t exp_c);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): expected data %02h last %0b, got data %02h last %0b",
               $realtime, what, exp_c.data, exp_c.eos, out_tdata, out_tlast);
  endfunction

  // Source side.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      src_gap   <= 0;
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata);
      if ($urandom_range(0, 39) == 0) src_calm <= !src_calm;
      if (!in_tvalid || in_tready) begin
        if (src_gap != 0) begin
          src_gap   <= src_gap - 1;
          in_tvalid <= 1'b0;
        end else if (idle_en && !src_calm && $urandom_range(0, 4) == 0) begin
          src_gap   <= $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (src_bytes.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= src_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap   <= 0;
      hold_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          note_mismatch("no result expected", '0);
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.eos)
            note_mismatch("wrong field", want);
        end
      end
      if ($urandom_range(0, 39) == 0) sink_calm <= !sink_calm;
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_reqs != holds_done) begin
        holds_done <= hold_reqs;
        hold_left  <= HOLD_LEN;
        out_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap   <= sink_gap - 1;
        out_tready <= 1'b0;
      end else if (idle_en && !sink_calm && $urandom_range(0, 4) == 0) begin
        sink_gap   <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    src_bytes.push_back(b);
    queued_total++;
  endtask

  // Pushes the n low bytes of s, most significant first.
  task automatic push_bytes(input logic [63:0] s, input int n);
    for (int i = n - 1; i >= 0; i--) push_byte(s[8*i +: 8]);
  endtask

  // Encodes cp as a len-octet sequence, keeping only the first keep continuations.
  task automatic push_code(input logic [30:0] cp, input int len, input int keep);
    logic [7:0] lead;
    case (len)
      2:       lead = 8'hc0;
      3:       lead = 8'he0;
      4:       lead = 8'hf0;
      5:       lead = 8'hf8;
      default: lead = 8'hfc;
    endcase
    if (len == 1) begin
      push_byte({1'b0, cp[6:0]});
    end else begin
      push_byte(lead | 8'(cp >> (6 * (len - 1))));
      for (int k = len - 2; k >= len - 1 - keep; k--)
        push_byte(8'h80 | 8'((cp >> (6 * k)) & 31'h3f));
    end
  endtask

  task automatic queue_random_text(input int n);
    int          start;
    int          kind;
    int          len;
    int          pick;
    logic [30:0] cp;
    start = queued_total;
    while (queued_total - start < n) begin
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      len  = (pick < 35) ? 1 : (pick < 60) ? 2 : (pick < 75) ? 3 :
             (pick < 85) ? 4 : (pick < 93) ? 5 : 6;
      if (kind < 6) begin
        push_byte(8'h00);
      end else if (kind < 78) begin
        case ($urandom_range(0, 7))
          0:       cp = code_low(len);
          1:       cp = code_high(len);
          default: cp = 31'($urandom_range(code_high(len), code_low(len)));
        endcase
        if (cp == '0) cp = 31'h1;
        push_code(cp, len, len - 1);
      end else if (kind < 84) begin
        if (len == 1) len = 2;
        cp = 31'($urandom_range(code_low(len) - 1, 0));
        push_code(cp, len, len - 1);
      end else if (kind < 90) begin
        if (len == 1) len = 2;
        cp = 31'($urandom_range(code_high(len), code_low(len)));
        push_code(cp, len, $urandom_range(len - 2, 0));
        case ($urandom_range(0, 2))
          0:       push_byte(8'h00);
          1:       push_byte(8'($urandom_range(8'h7f, 8'h01)));
          default: push_byte(8'($urandom_range(8'hff, 8'hc0)));
        endcase
      end else begin
        push_byte(8'($urandom_range(255, 1)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (src_bytes.size() != 0 || in_tvalid || expected_chars.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [u2l_pkg::CAP_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    capacity_reg = value;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_bytes(64'h7f, 1);
    push_bytes(64'hc3a9, 2);
    push_bytes(64'he08080, 3);
    push_bytes(64'hf7bfbfbf, 4);
    push_bytes(64'hf888808080, 5);
    push_bytes(64'hfdbfbfbfbfbf, 6);
    push_bytes(64'h80ff, 2);
    push_bytes(64'hc341, 2);
    push_bytes(64'he28200, 3);
    queue_random_text(450);
    repeat (40) @(negedge clk);
    hold_reqs++;
    wait_drained();

    write_capacity(16'd1);
    queue_random_text(100);
    wait_drained();

    write_capacity(16'd0);
    queue_random_text(60);
    wait_drained();

    write_capacity(16'd3);
    queue_random_text(250);
    wait_drained();

    write_capacity(16'($urandom_range(40, 5)));
    queue_random_text(300);
    repeat (60) @(negedge clk);
    hold_reqs++;
    wait_drained();

    idle_en = 1'b0;
    write_capacity(16'hffff);
    queue_random_text(400);
    wait_drained();

    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/u2l_pkg.sv
hdl/u2l_core.sv
hdl/utf8_to_latin1_decoder_top.sv
sim/tb_utf8_to_latin1_decoder_top.sv
